// ===== sv/ndt_pkg.sv =====
package ndt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned NAME_BYTES_DEF  = 8;

  // Fixed field widths of the stream items
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned NAME_W     = 64;
  localparam int unsigned STR_W      = 8;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 120;

  // Register file
  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned APB_DATA_W       = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = 3'd0;
  localparam logic [TIME_W-1:0]     TIMEOUT_RST  = 32'd5000;

  typedef enum logic [CMD_W-1:0] {
    CMD_UPSERT = 2'd0,
    CMD_SWEEP  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_DONE     = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_RD_ADDR,
    S_RD_DATA,
    S_FINISH
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // take the input transaction
    logic issue;     // read table entry at scan pointer
    logic issue_rd;  // read table entry at read index
    logic hit_wr;    // refresh matching entry
    logic ins_wr;    // append new entry
    logic drop;      // table full, sighting dropped
    logic keep_wr;   // compact surviving entry
    logic sweep_end; // commit new count after sweep
    logic rd_end;    // capture read result
    logic out_load;  // move result to output register
  } ctl_t;

  // Datapath -> controller
  typedef struct packed {
    logic can_issue; // scan pointer below entry count
    logic rv;        // read data valid this cycle
    logic match;     // read entry name equals sighting
    logic fresh;     // read entry younger than timeout
    logic full;      // table holds MaxEntries entries
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

// ===== sv/nearby_device_table_with_aging_top.sv =====
// Operation: upsert and sweep scan the stored entries, an upsert stopping early on a hit; a read
//   fetches one entry; a result stuck in the output register holds back the next transaction.
// Flow: one item at a time, the next transaction is taken in the cycle after the result loads;
//   the scan reads one entry per cycle through one read port.
// Reset: rst_ni clears the entry count, control state and the output valid; the timeout
//   register returns to 5000 ms. Table contents are not cleared and need no clearing pass.
module nearby_device_table_with_aging_top #(
  parameter int unsigned MaxEntries = ndt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned NameBytes  = ndt_pkg::NAME_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stream input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] peer_name, [71:64] signal_strength, [103:72] now_ms, [107:104] read_index
  input  logic [ndt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] command
  input  logic [ndt_pkg::CMD_W-1:0]          s_axis_tuser,
  // stream output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [4:0] entry_count, [9:5] removed_count, [73:10] entry_name,
  // [81:74] entry_strength, [113:82] entry_seen_ms
  output logic [ndt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [2:0] status
  output logic [ndt_pkg::STATUS_W-1:0]       m_axis_tuser,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ndt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ndt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ndt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import ndt_pkg::*;

  // Stale timeout register, byte address 0. A write lands in the access phase.
  logic [TIME_W-1:0] timeout_q, timeout_d;
  logic              reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TIMEOUT);

  always_comb begin
    timeout_d = timeout_q;
    if (reg_wr) begin
      timeout_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata = (paddr == ADDR_TIMEOUT) ? timeout_q : '0;

  // Unpack the input transaction
  logic [NAME_W-1:0]        in_name;
  logic signed [STR_W-1:0]  in_strength;
  logic [TIME_W-1:0]        in_now;
  logic [IDX_W-1:0]         in_index;
  cmd_e                     in_cmd;

  assign in_name     = s_axis_tdata[63:0];
  assign in_strength = s_axis_tdata[71:64];
  assign in_now      = s_axis_tdata[103:72];
  assign in_index    = s_axis_tdata[107:104];
  assign in_cmd      = cmd_e'(s_axis_tuser);

  ctl_t ctl;
  sts_t sts;

  // Controller walks the scan; datapath holds the table memory and result registers.
  ndt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (in_cmd),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  logic [STATUS_W-1:0]      out_status;
  logic [CNT_W-1:0]         out_count;
  logic [CNT_W-1:0]         out_removed;
  logic [NAME_W-1:0]        out_name;
  logic signed [STR_W-1:0]  out_strength;
  logic [TIME_W-1:0]        out_seen;

  ndt_datapath #(
    .MaxEntries (MaxEntries),
    .NameBytes  (NameBytes)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .name_i           (in_name),
    .strength_i       (in_strength),
    .now_i            (in_now),
    .index_i          (in_index),
    .timeout_i        (timeout_q),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .status_o         (out_status),
    .count_o          (out_count),
    .removed_o        (out_removed),
    .entry_name_o     (out_name),
    .entry_strength_o (out_strength),
    .entry_seen_o     (out_seen)
  );

  // Pack the result transaction, zero fill to whole bytes
  assign m_axis_tdata = {6'b0, out_seen, out_strength, out_name, out_removed, out_count};
  assign m_axis_tuser = out_status;

endmodule

// ===== sv/ndt_ram.sv =====
module ndt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ndt_ctrl.sv =====
module ndt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ndt_pkg::cmd_e  cmd_i,
  input  ndt_pkg::sts_t  sts_i,
  output ndt_pkg::ctl_t  ctl_o
);
  import ndt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          unique case (cmd_i)
            CMD_UPSERT: state_d = S_SCAN;
            CMD_SWEEP:  state_d = S_SWEEP;
            CMD_READ:   state_d = S_RD_ADDR;
            default:    state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (sts_i.rv && sts_i.match) begin
          ctl_o.hit_wr = 1'b1;
          state_d      = S_FINISH;
        end else if (!sts_i.rv && !sts_i.can_issue) begin
          if (sts_i.full) begin
            ctl_o.drop = 1'b1;
          end else begin
            ctl_o.ins_wr = 1'b1;
          end
          state_d = S_FINISH;
        end else begin
          ctl_o.issue = sts_i.can_issue;
        end
      end
      S_SWEEP: begin
        // reads run one entry ahead of the compaction write
        ctl_o.keep_wr = sts_i.rv && sts_i.fresh;
        if (!sts_i.rv && !sts_i.can_issue) begin
          ctl_o.sweep_end = 1'b1;
          state_d         = S_FINISH;
        end else begin
          ctl_o.issue = sts_i.can_issue;
        end
      end
      S_RD_ADDR: begin
        ctl_o.issue_rd = 1'b1;
        state_d        = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl_o.rd_end = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== sv/ndt_datapath.sv =====
module ndt_datapath #(
  parameter int unsigned MaxEntries = ndt_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned NameBytes  = ndt_pkg::NAME_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ndt_pkg::ctl_t                     ctl_i,
  output ndt_pkg::sts_t                     sts_o,
  input  logic [ndt_pkg::NAME_W-1:0]        name_i,
  input  logic signed [ndt_pkg::STR_W-1:0]  strength_i,
  input  logic [ndt_pkg::TIME_W-1:0]        now_i,
  input  logic [ndt_pkg::IDX_W-1:0]         index_i,
  input  logic [ndt_pkg::TIME_W-1:0]        timeout_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [ndt_pkg::STATUS_W-1:0]      status_o,
  output logic [ndt_pkg::CNT_W-1:0]         count_o,
  output logic [ndt_pkg::CNT_W-1:0]         removed_o,
  output logic [ndt_pkg::NAME_W-1:0]        entry_name_o,
  output logic signed [ndt_pkg::STR_W-1:0]  entry_strength_o,
  output logic [ndt_pkg::TIME_W-1:0]        entry_seen_o
);
  import ndt_pkg::*;

  localparam int unsigned CW = $clog2(MaxEntries + 1);
  localparam int unsigned AW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned NW = 8 * NameBytes;
  localparam int unsigned EW = NW + STR_W + TIME_W;

  // entry layout, low to high: name, strength, seen time
  logic [NW-1:0] norm_name;
  logic          alive;

  always_comb begin
    norm_name = '0;
    alive     = 1'b1;
    for (int unsigned b = 0; b < NameBytes; b++) begin
      if (name_i[8*b +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        norm_name[8*b +: 8] = name_i[8*b +: 8];
      end
    end
  end

  // item registers
  logic [NW-1:0]     name_q;
  logic [STR_W-1:0]  str_q;
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  rindex_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      name_q   <= norm_name;
      str_q    <= strength_i;
      now_q    <= now_i;
      rindex_q <= index_i;
    end
  end

  // scan control
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] iss_q, iss_d;
  logic [CW-1:0] wp_q, wp_d;
  logic          rv_q;
  logic [AW-1:0] ridx_q;
  logic [AW-1:0] raddr;

  assign raddr = ctl_i.issue_rd ? AW'(rindex_q) : iss_q[AW-1:0];

  always_comb begin
    iss_d   = iss_q;
    wp_d    = wp_q;
    count_d = count_q;
    if (ctl_i.load) begin
      iss_d = '0;
      wp_d  = '0;
    end
    if (ctl_i.issue) begin
      iss_d = iss_q + CW'(1);
    end
    if (ctl_i.keep_wr) begin
      wp_d = wp_q + CW'(1);
    end
    if (ctl_i.ins_wr) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.sweep_end) begin
      count_d = wp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      iss_q   <= '0;
      wp_q    <= '0;
      rv_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      iss_q   <= iss_d;
      wp_q    <= wp_d;
      rv_q    <= ctl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= raddr;
  end

  // table memory
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;

  always_comb begin
    we    = ctl_i.hit_wr || ctl_i.ins_wr || ctl_i.keep_wr;
    wdata = {now_q, str_q, name_q};
    waddr = ridx_q;
    if (ctl_i.ins_wr) begin
      waddr = count_q[AW-1:0];
    end else if (ctl_i.keep_wr) begin
      waddr = wp_q[AW-1:0];
      wdata = rdata;
    end
  end

  ndt_ram #(
    .Width (EW),
    .Depth (MaxEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [NW-1:0]     rd_name;
  logic [STR_W-1:0]  rd_str;
  logic [TIME_W-1:0] rd_seen;
  logic [TIME_W-1:0] age;
  logic              in_range;

  assign rd_name  = rdata[NW-1:0];
  assign rd_str   = rdata[NW +: STR_W];
  assign rd_seen  = rdata[NW+STR_W +: TIME_W];
  assign age      = now_q - rd_seen;
  assign in_range = 8'(rindex_q) < 8'(count_q);

  // pending result
  status_e           res_status_q;
  logic [CNT_W-1:0]  res_removed_q;
  logic [NW-1:0]     res_name_q;
  logic [STR_W-1:0]  res_str_q;
  logic [TIME_W-1:0] res_seen_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      res_status_q  <= ST_DONE;
      res_removed_q <= '0;
      res_name_q    <= '0;
      res_str_q     <= '0;
      res_seen_q    <= '0;
    end
    if (ctl_i.hit_wr) begin
      res_status_q <= ST_UPDATED;
    end
    if (ctl_i.ins_wr) begin
      res_status_q <= ST_INSERTED;
    end
    if (ctl_i.drop) begin
      res_status_q <= ST_DROPPED;
    end
    if (ctl_i.sweep_end) begin
      res_removed_q <= CNT_W'(count_q - wp_q);
    end
    if (ctl_i.rd_end) begin
      if (in_range) begin
        res_name_q <= rd_name;
        res_str_q  <= rd_str;
        res_seen_q <= rd_seen;
      end else begin
        res_status_q <= ST_RANGE;
      end
    end
  end

  // output register
  logic out_valid_q, out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_o         <= res_status_q;
      count_o          <= CNT_W'(count_q);
      removed_o        <= res_removed_q;
      entry_name_o     <= NAME_W'(res_name_q);
      entry_strength_o <= res_str_q;
      entry_seen_o     <= res_seen_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.can_issue = iss_q < count_q;
  assign sts_o.rv        = rv_q;
  assign sts_o.match     = rd_name == name_q;
  assign sts_o.fresh     = age < timeout_i;
  assign sts_o.full      = count_q == CW'(MaxEntries);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== bench/nearby_device_table_with_aging_top_tb.sv =====
module nearby_device_table_with_aging_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ndt_pkg::*;

  localparam int unsigned DEPTH      = MAX_ENTRIES_DEF;
  localparam int unsigned POOL_SIZE  = 24;   // more names than slots, so the table fills
  localparam int unsigned PHASE_LEN  = 275;  // random transactions per timeout setting
  localparam int unsigned SETTLE     = 24;   // extra wait after the last reply drains
  localparam int unsigned CYCLE_CAP  = 500000;

  // One input transaction and one output transaction, field by field
  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] name;
    logic [7:0]  strength;
    logic [31:0] now;
    logic [3:0]  idx;
  } sighting_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  count;
    logic [4:0]  removed;
    logic [63:0] name;
    logic [7:0]  strength;
    logic [31:0] seen;
  } table_reply_t;

  // Clock, reset and DUT pins; every input starts at a known value
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the peer table and the timeout register
  logic [63:0]  tbl_name   [DEPTH];
  logic [7:0]   tbl_strength [DEPTH];
  logic [31:0]  tbl_seen   [DEPTH];
  int unsigned  tbl_count = 0;
  logic [31:0]  timeout_model = TIMEOUT_RST;

  // Replies predicted but not yet seen on the output
  table_reply_t pending_replies[$];

  // Stimulus state
  logic [63:0]  name_pool [POOL_SIZE];
  logic [31:0]  wall_ms = '0;
  bit           idle_on = 1'b1;     // random bursts of idle on both sides
  int           rx_hold_left = 0;   // long receiver stall, counted down below
  int           rx_gap_left = 0;

  // Bookkeeping
  int           err_count = 0;
  int           replies_checked = 0;
  int           status_tally [5];
  int           timeout_settings = 0;
  int unsigned  cycle_count = 0;
  table_reply_t got_reply;
  table_reply_t want_reply;

  nearby_device_table_with_aging_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t ns: watchdog expired, %0d replies still pending", $time,
               pending_replies.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Keep bytes up to the first zero byte; everything from there on reads as zero.
  function automatic logic [63:0] trim_name(input logic [63:0] raw);
    logic [63:0] res;
    logic        ended;
    res   = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES_DEF; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) res[8*b +: 8] = raw[8*b +: 8];
    end
    return res;
  endfunction

  // Apply one accepted transaction to the shadow table and queue its reply.
  task automatic neighbor_table_step(input sighting_t it);
    table_reply_t r;
    logic [63:0]  key;
    logic         hit;
    int unsigned  kept;
    r   = '0;
    key = trim_name(it.name);
    hit = 1'b0;
    r.status = ST_DONE;
    case (it.cmd)
      CMD_UPSERT: begin
        // first match wins; names are unique anyway
        for (int i = 0; i < tbl_count; i++) begin
          if (!hit && tbl_name[i] == key) begin
            tbl_strength[i] = it.strength;
            tbl_seen[i]     = it.now;
            hit             = 1'b1;
          end
        end
        if (hit) begin
          r.status = ST_UPDATED;
        end else if (tbl_count < DEPTH) begin
          tbl_name[tbl_count]     = key;
          tbl_strength[tbl_count] = it.strength;
          tbl_seen[tbl_count]     = it.now;
          tbl_count++;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_DROPPED;
        end
      end
      CMD_SWEEP: begin
        // age wraps at 32 bits; survivors slide down in order
        kept = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (32'(it.now - tbl_seen[i]) < timeout_model) begin
            tbl_name[kept]     = tbl_name[i];
            tbl_strength[kept] = tbl_strength[i];
            tbl_seen[kept]     = tbl_seen[i];
            kept++;
          end
        end
        r.removed = 5'(tbl_count - kept);
        tbl_count = kept;
      end
      CMD_READ: begin
        if (it.idx < tbl_count) begin
          r.name     = tbl_name[it.idx];
          r.strength = tbl_strength[it.idx];
          r.seen     = tbl_seen[it.idx];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ; // unused command: count only
    endcase
    r.count = 5'(tbl_count);
    pending_replies.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one transaction; predict its reply at the edge where it is taken.
  task automatic send_item(input cmd_e cmd, input logic [63:0] name,
                           input logic [7:0] strength, input logic [31:0] now,
                           input logic [3:0] idx);
    sighting_t it;
    int        gap;
    it = '{cmd: cmd, name: name, strength: strength, now: now, idx: idx};
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, idx, now, strength, name};
    do @(posedge clk_i); while (!s_axis_tready);
    neighbor_table_step(it);
  endtask

  task automatic sight(input logic [63:0] name, input logic [7:0] strength,
                       input logic [31:0] now);
    send_item(CMD_UPSERT, name, strength, now, 4'($urandom));
  endtask

  task automatic sweep_at(input logic [31:0] now);
    send_item(CMD_SWEEP, 64'({$urandom, $urandom}), 8'($urandom), now, 4'($urandom));
  endtask

  task automatic read_entry(input logic [3:0] idx);
    send_item(CMD_READ, 64'({$urandom, $urandom}), 8'($urandom), $urandom, idx);
  endtask

  // Stop offering and let the table go quiet before touching the register.
  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic check_timeout_reg(input logic [31:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_TIMEOUT;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t ns: timeout register readback, expected %h, actual %h",
               $time, want, prdata);
      err_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write of the stale timeout, followed by a readback. Only called while idle.
  task automatic set_stale_timeout(input logic [31:0] value);
    drain_replies();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_TIMEOUT;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    timeout_model = value;
    timeout_settings++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_timeout_reg(value);
  endtask

  // Receiver: random short stalls, plus a long hold when a test asks for one
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Reply checker
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_reply.status   = status_e'(m_axis_tuser);
      got_reply.count    = m_axis_tdata[4:0];
      got_reply.removed  = m_axis_tdata[9:5];
      got_reply.name     = m_axis_tdata[73:10];
      got_reply.strength = m_axis_tdata[81:74];
      got_reply.seen     = m_axis_tdata[113:82];
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual %h_%h", $time,
                 m_axis_tuser, m_axis_tdata);
        err_count++;
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("status", 64'(want_reply.status), 64'(got_reply.status));
        check_field("entry_count", 64'(want_reply.count), 64'(got_reply.count));
        check_field("removed_count", 64'(want_reply.removed), 64'(got_reply.removed));
        check_field("entry_name", want_reply.name, got_reply.name);
        check_field("entry_strength", 64'(want_reply.strength), 64'(got_reply.strength));
        check_field("entry_seen_ms", 64'(want_reply.seen), 64'(got_reply.seen));
      end
      replies_checked++;
      if (m_axis_tuser <= ST_RANGE) status_tally[m_axis_tuser]++;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh out of reset: default timeout, empty table, unused command.
  task automatic test_empty_table();
    check_timeout_reg(TIMEOUT_RST);
    read_entry(4'd0);
    sweep_at(32'd0);
    send_item(CMD_NONE, '1, 8'hFF, '1, 4'hF);
  endtask

  // Insert, refresh and read back, with extreme names, strengths and times.
  task automatic test_upsert_and_read();
    sight(64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 32'h0000_0000);
    // leading zero byte: the whole name trims to zero
    sight(64'hA5A5_A5A5_A5A5_A500, 8'h7F, 32'hFFFF_FFFF);
    // "AB" followed by junk after the terminator
    sight(64'h1234_5678_9A00_4241, 8'h10, 32'd40);
    // same name, clean: must refresh the entry, not append
    sight(64'h0000_0000_0000_4241, 8'hF6, 32'd77);
    read_entry(4'd0);
    read_entry(4'd1);
    read_entry(4'd2);
    read_entry(4'd3);   // just past the end
    read_entry(4'd15);
    send_item(CMD_NONE, 64'h0, 8'h00, 32'h0, 4'h0);
  endtask

  // Aging: zero timeout, exact boundary, and ages that wrap past 2^32.
  task automatic test_sweep_aging();
    set_stale_timeout(32'd0);
    sweep_at(32'd123);               // nothing is younger than zero
    set_stale_timeout(32'd100);
    sight(64'h0000_0000_0041_4141, 8'd10, 32'd1000);
    sight(64'h0000_0000_0042_4242, 8'hFB, 32'd1050);
    sweep_at(32'd1100);              // first entry sits exactly at the timeout
    read_entry(4'd0);
    set_stale_timeout(32'hFFFF_FFFF);
    sight(64'h0000_0000_0043_4343, 8'd1, 32'hFFFF_FFF0);
    sweep_at(32'd5);                 // wrapped ages, all below the maximum
    sweep_at(32'd1049);              // age of the 1050 entry is all ones
    read_entry(4'd0);
  endtask

  // Hold the output off long enough that the input backs up, while filling
  // the table past capacity so sightings get dropped.
  task automatic test_full_table_backpressure();
    rx_hold_left = 60;
    for (int i = 0; i < 20; i++)
      sight({32'h0, 8'h50, 8'(8'h30 + i), 16'h4E44}, 8'($urandom), 32'(i));
    read_entry(4'd15);
    read_entry(4'd0);
  endtask

  // Add junk after the first zero byte of a trimmed name.
  function automatic logic [63:0] add_junk(input logic [63:0] nm);
    logic [63:0] raw;
    logic        ended;
    raw   = nm;
    ended = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (ended && $urandom_range(0, 1) == 1) raw[8*b +: 8] = 8'($urandom);
      if (nm[8*b +: 8] == 8'h00) ended = 1'b1;
    end
    return raw;
  endfunction

  // One timeout setting, a burst of mixed traffic over a shared name pool.
  task automatic random_phase(input logic [31:0] tmo, input int unsigned step_max);
    int unsigned pick;
    logic [31:0] now;
    logic [3:0]  idx;
    set_stale_timeout(tmo);
    for (int n = 0; n < PHASE_LEN; n++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) begin
        now = $urandom;                      // out-of-order time, large or negative age
      end else begin
        wall_ms += $urandom_range(0, step_max);
        now = wall_ms;
      end
      if (pick < 56) begin
        sight(add_junk(name_pool[$urandom_range(0, POOL_SIZE-1)]), 8'($urandom), now);
      end else if (pick < 70) begin
        sweep_at(now);
      end else if (pick < 96) begin
        if (tbl_count > 0 && $urandom_range(0, 4) != 0) idx = 4'($urandom_range(0, tbl_count-1));
        else idx = 4'($urandom);
        read_entry(idx);
      end else begin
        send_item(CMD_NONE, 64'({$urandom, $urandom}), 8'($urandom), now, 4'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned mid;
    // names of 0..8 nonzero bytes; the empty name is a legal key too
    for (int p = 0; p < POOL_SIZE; p++) begin
      name_pool[p] = '0;
      for (int b = 0; b < $urandom_range(0, 8); b++) name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end
    mid = $urandom_range(2, 100000);
    wall_ms = 32'hFFFF_F000;                // first phase runs across the wrap
    random_phase(TIMEOUT_RST, 900);
    random_phase(32'd300, 60);
    random_phase(32'd1, 2);
    random_phase(32'hFFFF_FFFF, 5000000);
    random_phase(mid, mid / 5 + 1);
    idle_on = 1'b0;                          // last stretch at full rate
    random_phase(32'd0, 50);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_upsert_and_read();
    test_sweep_aging();
    test_full_table_backpressure();
    test_random_traffic();
    drain_replies();

    $display("Checked %0d replies: %0d updated, %0d inserted, %0d dropped, %0d done, %0d out of range",
             replies_checked, status_tally[0], status_tally[1], status_tally[2],
             status_tally[3], status_tally[4]);
    $display("Timeout register set %0d times incl. 0, 1 and all ones; one long output stall",
             timeout_settings);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ndt_pkg.sv
sv/ndt_ram.sv
sv/ndt_ctrl.sv
sv/ndt_datapath.sv
sv/nearby_device_table_with_aging_top.sv
bench/nearby_device_table_with_aging_top_tb.sv
